FILE: sv/stg_pkg.sv
// Package for the sine tone generator: widths, register indexes, reset values,
// fixed-point sine coefficients and the sequencer state type.
// No dependencies; the top level, stg_front and stg_back import it.
`default_nettype none

package stg_pkg;

  // Field and port widths.
  localparam int PHASE_W    = 32;
  localparam int AMP_W      = 23;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_W      = 32;

  // Defaults for the top-level parameters.
  localparam int MAX_FRAMES_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 2'd1;

  // Register reset values (about 1 kHz at 44.1 kHz, amplitude near 0.1 full scale).
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd97391549;
  localparam logic [AMP_W-1:0]   AMPLITUDE_RST  = 23'd838861;

  // Q2.30 constants of the odd sine polynomial.
  localparam logic [MUL_W-1:0] PI_Q30  = 32'd3373259426;
  localparam logic [MUL_W-1:0] C1_Q30  = 32'd1073411097;
  localparam logic [MUL_W-1:0] C3_Q30  = 32'd177477835;
  localparam logic [MUL_W-1:0] C5_Q30  = 32'd7894653;
  localparam logic [MUL_W-1:0] ONE_Q30 = 32'd1073741824;

  // Back-end sequencer states: one multiply step per state after the reduction.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV,
    ST_RED,
    ST_X,
    ST_Y,
    ST_T5,
    ST_T3,
    ST_SIN,
    ST_MAG
  } seq_state_t;

endpackage

`default_nettype wire

FILE: sv/sine_tone_generator.sv
// Sine tone generator: a request asks for a number of audio samples and the
// block answers with one stereo frame per pair of samples, capped at MAX_FRAMES.
// Requests arrive on in_valid/in_ready with sample_count; frames leave on
// out_valid/out_ready with left_sample, right_sample (equal) and last_frame,
// which marks the final frame of a request. A request for zero samples is
// taken and produces nothing.
// The cfg port writes phase_step (index 0) and amplitude (index 1);
// cfg_ready is always high and other indexes are ignored.
// Each frame passes through the sample sequencer as one phase add, one
// half-turn reduction and six steps through the one shared 32x32 multiplier.
// A request occupies the back end until its last frame is loaded, and the
// sequencer returns to its idle state to take the next request from the queue;
// the first frame passes the queue entry, the idle state and ADV through MAG.
// A two-entry job queue lets up to two further requests be taken while a
// request is running. If the receiver stalls, the finished frame waits in the
// output register and the sequencer holds on the next frame.
// Reset clears the phase to zero and restores the register defaults.
// Depends on stg_pkg, stg_front, stg_queue and stg_back.
`default_nettype none

module sine_tone_generator #(
  parameter int MAX_FRAMES  = stg_pkg::MAX_FRAMES_DEF,
  parameter int SAMPLE_BITS = stg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [stg_pkg::COUNT_W-1:0]      sample_count,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [SAMPLE_BITS-1:0]         left_sample,
  output logic signed [SAMPLE_BITS-1:0]         right_sample,
  output logic                                  last_frame,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [stg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [stg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import stg_pkg::*;

  localparam int FW = $clog2(MAX_FRAMES + 1);

  logic [PHASE_W-1:0]           phase_step;
  logic [AMP_W-1:0]             amplitude;
  logic                         push_valid;
  logic                         push_ready;
  logic [FW-1:0]                push_frames;
  logic                         pop_valid;
  logic                         pop_ready;
  logic [FW-1:0]                pop_frames;
  logic signed [SAMPLE_BITS-1:0] sample;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= PHASE_STEP_RST;
      amplitude  <= AMPLITUDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_STEP: phase_step <= cfg_data;
        REG_AMPLITUDE:  amplitude  <= cfg_data[AMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request classification.
  stg_front #(
    .MAX_FRAMES (MAX_FRAMES),
    .FW         (FW)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_count(sample_count),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_frames (push_frames)
  );

  // Job queue between the two halves.
  stg_queue #(
    .W (FW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_frames),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_frames)
  );

  // Sample sequencer and output register.
  stg_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FW          (FW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .phase_step(phase_step),
    .amplitude (amplitude),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_frames(pop_frames),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .last_frame(last_frame)
  );

  // Both channels carry the same sample.
  assign left_sample  = sample;
  assign right_sample = sample;

  // After reset no frame is pending and requests can be taken.
  a_reset_clear: assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("output or input side not cleared by reset");

  // Saturation keeps the most negative code out of every frame.
  a_no_min_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_sample != {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
    else $error("sample reached the most negative code");

  // Stereo channels agree on every presented frame.
  a_stereo_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_sample == right_sample))
    else $error("left and right samples differ");

endmodule

`default_nettype wire

FILE: sv/stg_front.sv
// Front end of the sine tone generator: turns a sample count into a frame count.
// Depends on stg_pkg; feeds the job queue.
`default_nettype none

module stg_front #(
  parameter int MAX_FRAMES = 32,
  parameter int FW         = 6
) (
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [stg_pkg::COUNT_W-1:0] sample_count,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output logic [FW-1:0]                    push_frames
);
  import stg_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_FRAMES);

  logic [COUNT_W:0]   count_inc;
  logic [COUNT_W-1:0] frames_raw;
  logic [COUNT_W-1:0] frames_cap;

  // Two samples make one frame, rounding up; cap at the frame limit.
  always_comb begin
    count_inc  = {1'b0, sample_count} + (COUNT_W+1)'(1);
    frames_raw = count_inc[COUNT_W:1];
    frames_cap = (frames_raw > MAX_CNT) ? MAX_CNT : frames_raw;
  end

  // A request for no frames is taken and dropped without reaching the queue.
  assign in_ready    = push_ready;
  assign push_valid  = in_valid && (frames_cap != '0);
  assign push_frames = frames_cap[FW-1:0];

endmodule

`default_nettype wire

FILE: sv/stg_queue.sv
// Two-entry job queue between the front end and the sample sequencer.
// Depends on nothing but its width parameter.
`default_nettype none

module stg_queue #(
  parameter int W = 6
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic [W-1:0]      pop_data
);

  logic [W-1:0] entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: sv/stg_back.sv
// Back end of the sine tone generator: phase accumulator, a shared 32x32
// multiplier stepped by a sequencer, and the output register. Depends on stg_pkg.
`default_nettype none

module stg_back #(
  parameter int SAMPLE_BITS = 24,
  parameter int FW          = 6
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [stg_pkg::PHASE_W-1:0]    phase_step,
  input  wire logic [stg_pkg::AMP_W-1:0]      amplitude,
  input  wire logic                           pop_valid,
  output logic                                pop_ready,
  input  wire logic [FW-1:0]                  pop_frames,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                last_frame
);
  import stg_pkg::*;

  localparam logic [MUL_W-1:0] LIM = MUL_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

  seq_state_t state;
  seq_state_t state_next;

  logic [PHASE_W-1:0]   phase;
  logic [FW-1:0]        remaining;
  logic [30:0]          mr;
  logic                 neg;
  logic [30:0]          x;
  logic [MUL_W-1:0]     y;
  logic [MUL_W-1:0]     acc;

  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [2*MUL_W-1:0]   prod;
  logic                 out_free;
  logic                 load_out;

  logic [PHASE_W:0]     ph_ext;
  logic [PHASE_W:0]     ph_round;
  logic [1:0]           k;
  logic [PHASE_W:0]     base;
  logic [PHASE_W:0]     diff;
  logic                 below;
  logic [MUL_W-1:0]     t3;
  logic [MUL_W-1:0]     p;
  logic [MUL_W-1:0]     s_raw;
  logic [MUL_W-1:0]     mag_raw;
  logic [MUL_W-1:0]     mag;
  logic [MUL_W-1:0]     signed_mag;

  assign out_free = !out_valid || out_ready;

  // Reduction to the nearest multiple of a half turn.
  always_comb begin
    ph_ext   = {1'b0, phase};
    ph_round = ph_ext + (PHASE_W+1)'(33'h040000000);
    k        = ph_round[PHASE_W:PHASE_W-1];
    base     = {k, {(PHASE_W-1){1'b0}}};
    below    = (ph_ext < base);
    diff     = below ? (base - ph_ext) : (ph_ext - base);
  end

  // Operand corrections between multiply steps.
  always_comb begin
    t3         = (acc < C3_Q30) ? (C3_Q30 - acc) : '0;
    p          = (acc < C1_Q30) ? (C1_Q30 - acc) : '0;
    s_raw      = prod[61:30];
    mag_raw    = {8'd0, prod[53:30]};
    mag        = (mag_raw > LIM) ? LIM : mag_raw;
    signed_mag = neg ? (MUL_W'(0) - mag) : mag;
  end

  // Shared multiplier.
  assign prod = mul_a * mul_b;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, multiplier operand selection and handshake controls.
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    pop_ready  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = ST_ADV;
        end
      end
      ST_ADV: begin
        state_next = ST_RED;
      end
      ST_RED: begin
        state_next = ST_X;
      end
      ST_X: begin
        mul_a      = {1'b0, mr};
        mul_b      = PI_Q30;
        state_next = ST_Y;
      end
      ST_Y: begin
        mul_a      = {1'b0, x};
        mul_b      = {1'b0, x};
        state_next = ST_T5;
      end
      ST_T5: begin
        mul_a      = C5_Q30;
        mul_b      = y;
        state_next = ST_T3;
      end
      ST_T3: begin
        mul_a      = t3;
        mul_b      = y;
        state_next = ST_SIN;
      end
      ST_SIN: begin
        mul_a      = {1'b0, x};
        mul_b      = p;
        state_next = ST_MAG;
      end
      ST_MAG: begin
        mul_a = acc;
        mul_b = {{(MUL_W-AMP_W){1'b0}}, amplitude};
        if (out_free) begin
          load_out   = 1'b1;
          state_next = (remaining == FW'(1)) ? ST_IDLE : ST_ADV;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Phase accumulator and frame counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      remaining <= '0;
    end else begin
      if (state == ST_IDLE && pop_valid) begin
        remaining <= pop_frames;
      end else if (load_out) begin
        remaining <= remaining - FW'(1);
      end
      if (state == ST_ADV) begin
        phase <= phase + phase_step;
      end
    end
  end

  // Datapath registers, one multiply result per step.
  always_ff @(posedge clk) begin
    case (state)
      ST_RED: begin
        mr  <= diff[30:0];
        neg <= below ^ k[0];
      end
      ST_X: begin
        x <= prod[61:31];
      end
      ST_Y: begin
        y <= prod[61:30];
      end
      ST_T5: begin
        acc <= prod[61:30];
      end
      ST_T3: begin
        acc <= prod[61:30];
      end
      ST_SIN: begin
        acc <= (s_raw > ONE_Q30) ? ONE_Q30 : s_raw;
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a finished frame until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample     <= signed_mag[SAMPLE_BITS-1:0];
      last_frame <= (remaining == FW'(1));
    end
  end

endmodule

`default_nettype wire
